### hdl/go_back_n_window_sender_defines.svh
// ----------------------------------------------------------------------------
// go_back_n_window_sender_defines.svh
// Assertion macros used by the go-back-N sender.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_WINDOW_SENDER_DEFINES_SVH
`define GO_BACK_N_WINDOW_SENDER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset
`define GBN_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define GBN_ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

`endif

### hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and fixed constants of the go-back-N window sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int CHUNK_BYTES = 6;
    localparam int PAYLOAD_W   = 8 * CHUNK_BYTES;
    localparam int BYTE_IDX_W  = 3;
    localparam int ACK_W       = 13;
    localparam int SEQ_W       = 10;
    localparam int SEQ_CHAR_W  = 6;
    localparam int SUM_W       = 11;
    localparam int REM_W       = 4;

    // Configuration
    localparam int WLIM_W     = 5;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [WLIM_W-1:0]    WINDOW_LIMIT_RST = 5'd4;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd50;

    // Timer
    localparam int TICK_W = 17;
    localparam logic [TICK_W-1:0] TICK_SAT = 17'h1FFFF;

    // Shared multiply-add unit
    localparam int MAC_A_W = 14;
    localparam int MAC_B_W = 14;
    localparam int MAC_C_W = 16;
    localparam int MAC_Y_W = MAC_A_W + MAC_B_W;

    // Reciprocal division: q = (x * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_W      = 12;
    localparam logic [MAC_B_W-1:0] ACK_RECIP   = 14'd9363;  // divide by 7
    localparam logic [MAC_B_W-1:0] DIV10_RECIP = 14'd6554;  // divide by 10
    localparam logic [MAC_B_W-1:0] DECIMAL_BASE = 14'd10;
    localparam logic [MAC_B_W-1:0] UNIT_GAIN    = 14'd1;

    localparam logic [SEQ_CHAR_W-1:0] SEQ_CHAR_BASE = 6'h30;  // ASCII zero

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LIMIT  = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK_MARK,
        ST_WALK,
        ST_WALK_CHK,
        ST_SCAN,
        ST_MOD,
        ST_SUM,
        ST_EMIT
    } state_t;

    // Request to the shared unit: y = c + a*b, or c - a*b when sub is set
    typedef struct packed {
        logic               sub;
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
        logic [MAC_C_W-1:0] c;
    } mac_req_t;

endpackage

### hdl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/gbn_mac.sv
// ----------------------------------------------------------------------------
// gbn_mac
// Shared multiply-add/subtract unit used by the sender's sequencer.
// ----------------------------------------------------------------------------
module gbn_mac (
    input  gbn_pkg::mac_req_t            req,
    output logic [gbn_pkg::MAC_Y_W-1:0]  y
);

    import gbn_pkg::*;

    logic [MAC_Y_W-1:0] prod;
    logic [MAC_Y_W-1:0] addend;

    // Multiply, then add to or subtract from the accumulator operand
    assign prod   = MAC_Y_W'(req.a) * MAC_Y_W'(req.b);
    assign addend = MAC_Y_W'(req.c);
    assign y      = req.sub ? (addend - prod) : (addend + prod);

endmodule

### hdl/go_back_n_window_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_window_sender
// Go-back-N sliding-window sender: chunk store, acknowledgement tracking,
// retransmit timer and packet emission with sequence digit and byte sum.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_ready is high only while the sequencer is
// idle. A load, start or tick item is applied on acceptance and then goes to
// the window scan. An acknowledgement divides the ack number by seven, marks
// its chunk, then walks the window base over every acknowledged chunk (one
// mark-store read each) until it finds where the walk stops. Then every packet
// the window allows takes the chunk-store read and the divide by ten, then the
// remainder, then the sum of the six payload bytes (one byte per cycle through
// the shared multiply-add unit) and then the load of the output register, which
// may stretch while m_ready is low. A final window scan closes the item. The
// mark store needs no clearing pass after reset: each load writes a clear mark
// for the entry it fills, and only entries below the chunk count are ever read.
// ----------------------------------------------------------------------------
`include "go_back_n_window_sender_defines.svh"

module go_back_n_window_sender #(
    parameter int STORE_DEPTH = 1024,
    parameter int WINDOW_MAX  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gbn_pkg::CMD_W-1:0]           s_command,
    input  logic [gbn_pkg::PAYLOAD_W-1:0]       s_chunk_bytes,
    input  logic [gbn_pkg::ACK_W-1:0]           s_ack_value,
    // Packets
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gbn_pkg::SEQ_W-1:0]           m_seq_number,
    output logic [gbn_pkg::SEQ_CHAR_W-1:0]      m_seq_char,
    output logic [gbn_pkg::PAYLOAD_W-1:0]       m_payload_out,
    output logic [gbn_pkg::SUM_W-1:0]           m_sum_out,
    output logic                                m_last_packet,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import gbn_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int LIM_W  = CNT_W + 1;
    localparam int NCNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (CNT_W > QUOT_W) ? CNT_W : QUOT_W;

    // Control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    chunk_count_reg, chunk_count_next;
    logic [CNT_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]    nts_reg, nts_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic                running_reg, running_next;
    logic [NCNT_W-1:0]   n_reg, n_next;
    logic                m_valid_reg, m_valid_next;

    // Working registers
    logic [MAC_Y_W-1:0]    alu_reg, alu_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [PAYLOAD_W-1:0]  data_reg, data_next;
    logic [BYTE_IDX_W-1:0] bi_reg, bi_next;

    // Output payload registers
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [SEQ_CHAR_W-1:0] char_reg, char_next;
    logic [PAYLOAD_W-1:0]  pay_reg, pay_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  last_reg, last_next;

    // Configuration registers
    logic [WLIM_W-1:0]    window_limit_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Memories and shared unit
    logic                 chunk_we, chunk_re;
    logic [ADDR_W-1:0]    chunk_waddr, chunk_raddr;
    logic [PAYLOAD_W-1:0] chunk_rdata;
    logic                 mark_we, mark_re, mark_wdata;
    logic [ADDR_W-1:0]    mark_waddr, mark_raddr;
    logic                 mark_rdata;
    mac_req_t             mac_req;
    logic [MAC_Y_W-1:0]   mac_y;

    // Derived values
    logic [LIM_W-1:0]   win;
    logic [LIM_W-1:0]   win_end;
    logic [CNT_W-1:0]   nts_inc;
    logic [NCNT_W-1:0]  n_inc;
    logic [TICK_W-1:0]  elapsed_inc;
    logic [QUOT_W-1:0]  ack_idx;
    logic               can_send;
    logic               more_after;
    logic               s_xfer;

    gbn_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (STORE_DEPTH)
    ) u_chunk_ram (
        .aclk  (aclk),
        .we    (chunk_we),
        .waddr (chunk_waddr),
        .wdata (s_chunk_bytes),
        .re    (chunk_re),
        .raddr (chunk_raddr),
        .rdata (chunk_rdata)
    );

    gbn_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    gbn_mac u_mac (
        .req (mac_req),
        .y   (mac_y)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_xfer        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_seq_number  = seq_reg;
    assign m_seq_char    = char_reg;
    assign m_payload_out = pay_reg;
    assign m_sum_out     = sum_reg;
    assign m_last_packet = last_reg;

    // Clamp the window limit to one through the window maximum
    always_comb begin
        if (window_limit_reg == '0) begin
            win = LIM_W'(1);
        end else if (int'(window_limit_reg) > WINDOW_MAX) begin
            win = LIM_W'(WINDOW_MAX);
        end else begin
            win = LIM_W'(window_limit_reg);
        end
    end

    assign win_end     = LIM_W'(base_reg) + win;
    assign nts_inc     = nts_reg + CNT_W'(1);
    assign n_inc       = n_reg + NCNT_W'(1);
    assign elapsed_inc = (elapsed_reg != TICK_SAT) ? (elapsed_reg + TICK_W'(1)) : elapsed_reg;
    assign ack_idx     = alu_reg[RECIP_SHIFT +: QUOT_W];

    // Window check for the packet at next_to_send, and for the one after it
    assign can_send   = running_reg && (LIM_W'(nts_reg) < win_end) &&
                        (nts_reg < chunk_count_reg) && (n_reg < NCNT_W'(WINDOW_MAX));
    assign more_after = (LIM_W'(nts_inc) < win_end) && (nts_inc < chunk_count_reg) &&
                        (n_inc < NCNT_W'(WINDOW_MAX));

    // Sequencer: next state, memory strobes and shared unit requests
    always_comb begin
        state_next       = state_reg;
        chunk_count_next = chunk_count_reg;
        base_next        = base_reg;
        nts_next         = nts_reg;
        elapsed_next     = elapsed_reg;
        running_next     = running_reg;
        n_next           = n_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        alu_next         = alu_reg;
        rem_next         = rem_reg;
        data_next        = data_reg;
        bi_next          = bi_reg;
        seq_next         = seq_reg;
        char_next        = char_reg;
        pay_next         = pay_reg;
        sum_next         = sum_reg;
        last_next        = last_reg;
        chunk_we         = 1'b0;
        chunk_waddr      = chunk_count_reg[ADDR_W-1:0];
        chunk_re         = 1'b0;
        chunk_raddr      = nts_reg[ADDR_W-1:0];
        mark_we          = 1'b0;
        mark_waddr       = chunk_count_reg[ADDR_W-1:0];
        mark_wdata       = 1'b0;
        mark_re          = 1'b0;
        mark_raddr       = base_reg[ADDR_W-1:0];
        mac_req          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_next     = '0;
                    state_next = ST_SCAN;
                    unique case (cmd_t'(s_command))
                        CMD_LOAD: begin
                            // Append the chunk and clear its mark
                            if (chunk_count_reg < CNT_W'(STORE_DEPTH)) begin
                                chunk_we         = 1'b1;
                                mark_we          = 1'b1;
                                chunk_count_next = chunk_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_START: begin
                            if (!running_reg) begin
                                elapsed_next = '0;
                            end
                            running_next = 1'b1;
                        end
                        CMD_ACK: begin
                            // Divide the ack number by seven
                            mac_req.a  = MAC_A_W'(s_ack_value);
                            mac_req.b  = ACK_RECIP;
                            alu_next   = mac_y;
                            state_next = ST_ACK_MARK;
                        end
                        CMD_TICK: begin
                            // Advance the timer, go back to the base on timeout
                            if (running_reg) begin
                                if (elapsed_inc > {1'b0, timeout_reg}) begin
                                    nts_next     = base_reg;
                                    elapsed_next = '0;
                                end else begin
                                    elapsed_next = elapsed_inc;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_ACK_MARK: begin
                // Mark the chunk if it lies below the loaded count
                if (CMP_W'(ack_idx) < CMP_W'(chunk_count_reg)) begin
                    mark_we    = 1'b1;
                    mark_waddr = ack_idx[ADDR_W-1:0];
                    mark_wdata = 1'b1;
                end
                state_next = ST_WALK;
            end

            ST_WALK: begin
                if (base_reg < chunk_count_reg) begin
                    mark_re    = 1'b1;
                    state_next = ST_WALK_CHK;
                end else begin
                    if (nts_reg < base_reg) begin
                        nts_next = base_reg;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_WALK_CHK: begin
                // Step the base past an acknowledged chunk
                if (mark_rdata) begin
                    base_next  = base_reg + CNT_W'(1);
                    state_next = ST_WALK;
                end else begin
                    if (nts_reg < base_reg) begin
                        nts_next = base_reg;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (can_send) begin
                    // Fetch the chunk and start the divide by ten
                    chunk_re   = 1'b1;
                    mac_req.a  = MAC_A_W'(nts_reg);
                    mac_req.b  = DIV10_RECIP;
                    alu_next   = mac_y;
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_MOD: begin
                // Remainder = index - quotient * 10
                mac_req.sub = 1'b1;
                mac_req.a   = MAC_A_W'(alu_reg[RECIP_SHIFT +: QUOT_W]);
                mac_req.b   = DECIMAL_BASE;
                mac_req.c   = MAC_C_W'(nts_reg);
                rem_next    = mac_y[REM_W-1:0];
                data_next   = chunk_rdata;
                alu_next    = '0;
                bi_next     = '0;
                state_next  = ST_SUM;
            end

            ST_SUM: begin
                // Accumulate one payload byte per cycle
                mac_req.a = MAC_A_W'(data_reg[{bi_reg, 3'b000} +: 8]);
                mac_req.b = UNIT_GAIN;
                mac_req.c = alu_reg[MAC_C_W-1:0];
                alu_next  = mac_y;
                if (int'(bi_reg) == CHUNK_BYTES - 1) begin
                    state_next = ST_EMIT;
                end else begin
                    bi_next = bi_reg + BYTE_IDX_W'(1);
                end
            end

            ST_EMIT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    seq_next     = SEQ_W'(nts_reg);
                    char_next    = SEQ_CHAR_BASE + SEQ_CHAR_W'(rem_reg);
                    pay_next     = data_reg;
                    sum_next     = alu_reg[SUM_W-1:0];
                    last_next    = !more_after;
                    if (nts_reg == base_reg) begin
                        elapsed_next = '0;
                    end
                    nts_next   = nts_inc;
                    n_next     = n_inc;
                    state_next = ST_SCAN;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            chunk_count_reg <= '0;
            base_reg        <= '0;
            nts_reg         <= '0;
            elapsed_reg     <= '0;
            running_reg     <= 1'b0;
            n_reg           <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            chunk_count_reg <= chunk_count_next;
            base_reg        <= base_next;
            nts_reg         <= nts_next;
            elapsed_reg     <= elapsed_next;
            running_reg     <= running_next;
            n_reg           <= n_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        alu_reg  <= alu_next;
        rem_reg  <= rem_next;
        data_reg <= data_next;
        bi_reg   <= bi_next;
        seq_reg  <= seq_next;
        char_reg <= char_next;
        pay_reg  <= pay_next;
        sum_reg  <= sum_next;
        last_reg <= last_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_limit_reg <= WINDOW_LIMIT_RST;
            timeout_reg      <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LIMIT:  window_limit_reg <= cfg_wdata[WLIM_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg      <= cfg_wdata[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Assertions
    `GBN_ASSERT_ALWAYS(a_base_le_count, aclk, aresetn, base_reg <= chunk_count_reg,
        "window base passed the chunk count")
    `GBN_ASSERT_IMPLY(a_idle_nts_range, aclk, aresetn, state_reg == ST_IDLE,
        (base_reg <= nts_reg) && (nts_reg <= chunk_count_reg),
        "next_to_send outside base and count while idle")
    `GBN_ASSERT_ALWAYS(a_burst_bound, aclk, aresetn, n_reg <= NCNT_W'(WINDOW_MAX),
        "more packets than the window maximum for one item")
    `GBN_ASSERT_IMPLY(a_send_only_running, aclk, aresetn, $rose(m_valid_reg), running_reg,
        "packet emitted while sending is stopped")

endmodule

### verif/go_back_n_window_sender_test.sv
// ----------------------------------------------------------------------------
// go_back_n_window_sender_test
// Self-checking bench for the go-back-N window sender. Load, start, ack and
// tick transfers go in; a local copy of the sender state predicts every packet,
// and each packet that comes out is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module go_back_n_window_sender_test;
    import gbn_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int WINDOW_MAX   = 16;
    localparam int ACK_STEP     = 7;
    localparam int ACK_TOP      = STORE_DEPTH * ACK_STEP - 1;
    localparam int STALL_LIMIT  = 12000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SEQ_W-1:0]      seq_no;
        logic [SEQ_CHAR_W-1:0] digit;
        logic [PAYLOAD_W-1:0]  payload;
        logic [SUM_W-1:0]      byte_sum;
        logic                  last_flag;
    } packet_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command;
    logic [PAYLOAD_W-1:0]  s_chunk_bytes;
    logic [ACK_W-1:0]      s_ack_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [SEQ_W-1:0]      m_seq_number;
    logic [SEQ_CHAR_W-1:0] m_seq_char;
    logic [PAYLOAD_W-1:0]  m_payload_out;
    logic [SUM_W-1:0]      m_sum_out;
    logic                  m_last_packet;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Local copy of the sender state
    logic [PAYLOAD_W-1:0]  chunk_mem [STORE_DEPTH];
    logic                  acked [STORE_DEPTH];
    logic [10:0]           loaded_count;
    logic [10:0]           base_idx;
    logic [10:0]           send_idx;
    logic [TICK_W-1:0]     tick_count;
    logic                  sending;
    logic [WLIM_W-1:0]     win_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    int                    walk_len;
    packet_t               packets_due[$];

    bit idle_on = 1'b1;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int packets_seen = 0;
    int reg_writes = 0;
    int item_tally [4];

    go_back_n_window_sender i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_chunk_bytes (s_chunk_bytes),
        .s_ack_value   (s_ack_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_seq_number  (m_seq_number),
        .m_seq_char    (m_seq_char),
        .m_payload_out (m_payload_out),
        .m_sum_out     (m_sum_out),
        .m_last_packet (m_last_packet),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp the window register to the usable range
    function automatic int window_span();
        int w;
        w = int'(win_reg);
        if (w < 1) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    // Apply one accepted item to the local state and queue the packets it sends
    function automatic void advance_sender(cmd_t cmd, logic [PAYLOAD_W-1:0] chunk,
                                           logic [ACK_W-1:0] ack);
        int      idx;
        int      win;
        int      burst;
        packet_t pkt;
        walk_len = 0;
        case (cmd)
            CMD_LOAD: begin
                if (loaded_count < STORE_DEPTH) begin
                    chunk_mem[loaded_count[9:0]] = chunk;
                    acked[loaded_count[9:0]] = 1'b0;
                    loaded_count++;
                end
            end
            CMD_START: begin
                if (!sending) tick_count = '0;
                sending = 1'b1;
            end
            CMD_ACK: begin
                idx = int'(ack) / ACK_STEP;
                if (idx < loaded_count) acked[idx] = 1'b1;
                while (base_idx < loaded_count && acked[base_idx[9:0]]) begin
                    base_idx++;
                    walk_len++;
                end
                if (send_idx < base_idx) send_idx = base_idx;
            end
            default: begin
                if (sending) begin
                    if (tick_count < TICK_SAT) tick_count++;
                    if (tick_count > timeout_reg) begin
                        send_idx = base_idx;
                        tick_count = '0;
                    end
                end
            end
        endcase
        if (!sending) return;
        // Send everything the window allows, flag the final packet
        win = window_span();
        burst = 0;
        while (send_idx < base_idx + win && send_idx < loaded_count && burst < WINDOW_MAX) begin
            pkt.seq_no = send_idx[SEQ_W-1:0];
            pkt.digit = SEQ_CHAR_BASE + SEQ_CHAR_W'(send_idx % 10);
            pkt.payload = chunk_mem[send_idx[9:0]];
            pkt.byte_sum = '0;
            for (int b = 0; b < CHUNK_BYTES; b++) pkt.byte_sum += pkt.payload[8*b +: 8];
            pkt.last_flag = 1'b0;
            if (send_idx == base_idx) tick_count = '0;
            packets_due.push_back(pkt);
            send_idx++;
            burst++;
        end
        if (burst > 0) begin
            pkt = packets_due.pop_back();
            pkt.last_flag = 1'b1;
            packets_due.push_back(pkt);
        end
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_chunk();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[PAYLOAD_W-1:0];
    endfunction

    function automatic logic [ACK_W-1:0] random_ack();
        return ACK_W'($urandom_range(0, ACK_TOP));
    endfunction

    function automatic logic [ACK_W-1:0] ack_for(int idx);
        return ACK_W'(idx * ACK_STEP + $urandom_range(0, ACK_STEP - 1));
    endfunction

    // Drive one item, hold it until the transfer, then predict its packets
    task automatic send_item(cmd_t cmd, logic [PAYLOAD_W-1:0] chunk, logic [ACK_W-1:0] ack);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_chunk_bytes <= chunk;
        s_ack_value <= ack;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_sender(cmd, chunk, ack);
        item_tally[cmd]++;
    endtask

    task automatic do_load(logic [PAYLOAD_W-1:0] chunk);
        send_item(CMD_LOAD, chunk, random_ack());
    endtask

    task automatic do_ack(logic [ACK_W-1:0] ack);
        send_item(CMD_ACK, random_chunk(), ack);
    endtask

    task automatic do_tick();
        send_item(CMD_TICK, random_chunk(), random_ack());
    endtask

    task automatic do_start();
        send_item(CMD_START, random_chunk(), random_ack());
    endtask

    // Drop valid, wait for every packet, then let a trailing walk finish
    task automatic settle_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge aclk);
        repeat (2 * walk_len + 40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_LIMIT) win_reg = data[WLIM_W-1:0];
        else timeout_reg = data[TIMEOUT_W-1:0];
        reg_writes++;
    endtask

    // Window write carries junk in the unused upper bits
    task automatic apply_settings(int wlim, int timeout);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[WLIM_W-1:0] = WLIM_W'(wlim);
        write_reg(CFG_WINDOW_LIMIT, data);
        write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
    endtask

    // Reset settings: payload extremes, early acks, repeated start, ack ranges
    task automatic test_defaults_and_acks();
        do_ack('0);
        do_load('0);
        do_load({PAYLOAD_W{1'b1}});
        do_load(48'hAA55_AA55_AA55);
        do_load(48'h0123_4567_89AB);
        // acknowledge chunk 0 before anything is sent; ticks idle while stopped
        do_ack(ACK_W'(6));
        do_tick();
        do_load(48'h55AA_55AA_55AA);
        do_start();
        do_start();
        do_load(48'hFEDC_BA98_7654);
        do_ack(ACK_W'(ACK_TOP));
        // mark out of order, then close the gap so the base walks
        do_ack(ACK_W'(20));
        do_ack(ACK_W'(7));
        do_load(48'h8000_0000_0001);
        do_load(48'h7FFF_FFFF_FFFE);
        do_ack(ACK_W'(27));
    endtask

    // Zero window limit acts as one; a timeout of one tick forces go-back
    task automatic test_timer_go_back();
        settle_sender();
        write_reg(CFG_WINDOW_LIMIT, '0);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        repeat (3) do_tick();
        do_ack(ack_for(int'(base_idx)));
        repeat (2) do_load(random_chunk());
        repeat (3) do_tick();
        do_ack(ack_for(int'(base_idx)));
    endtask

    // Mostly well-formed traffic: acks aimed at the window, some stray ones
    task automatic random_item();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 7) == 0)
                do_load($urandom_range(0, 1) ? {PAYLOAD_W{1'b1}} : {PAYLOAD_W{1'b0}});
            else
                do_load(random_chunk());
        end else if (pick < 62 && loaded_count != 0) begin
            if ($urandom_range(0, 4) == 0) idx = $urandom_range(0, loaded_count - 1);
            else idx = base_idx + $urandom_range(0, window_span() - 1);
            if (idx >= loaded_count) idx = loaded_count - 1;
            do_ack(ack_for(idx));
        end else if (pick < 90) begin
            do_tick();
        end else if (pick < 93) begin
            do_start();
        end else begin
            do_ack(random_ack());
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            settle_sender();
            idle_on = (phase != 1);
            case (phase)
                0: apply_settings(WINDOW_MAX, $urandom_range(1, 8));
                1: apply_settings($urandom_range(2, 15), 65535);
                2: apply_settings(1, $urandom_range(3, 30));
                default: apply_settings($urandom_range(17, 31), $urandom_range(1, 20));
            endcase
            repeat (30) random_item();
        end
    endtask

    // Acknowledge a run out of order, then close the gap so the base walks far
    task automatic test_long_walk();
        int top;
        settle_sender();
        idle_on = 1'b0;
        apply_settings(31, 3);
        repeat (16) do_load(random_chunk());
        top = int'(loaded_count) - 1;
        for (int k = top; k > int'(base_idx) && k > top - 16; k--) do_ack(ack_for(k));
        do_ack(ACK_W'(ACK_TOP));
        do_ack(ack_for(int'(base_idx)));
        repeat (4) begin
            do_tick();
            do_load(random_chunk());
        end
    endtask

    // Stall the packet side in random bursts
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) hold_cycles <= $urandom_range(1, 14);
        end
    end

    // Compare each packet transfer with the oldest predicted packet
    always @(posedge aclk) begin : check_packets
        packet_t want;
        if (aresetn && m_valid && m_ready) begin
            packets_seen++;
            if (packets_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected packet seq %0d char %0d payload %h sum %0d last %0b",
                             $realtime, m_seq_number, m_seq_char, m_payload_out, m_sum_out,
                             m_last_packet);
            end else begin
                want = packets_due.pop_front();
                if (m_seq_number !== want.seq_no || m_seq_char !== want.digit ||
                    m_payload_out !== want.payload || m_sum_out !== want.byte_sum ||
                    m_last_packet !== want.last_flag) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: packet mismatch", $realtime);
                        $display("  expected seq %0d char %0d payload %h sum %0d last %0b",
                                 want.seq_no, want.digit, want.payload, want.byte_sum,
                                 want.last_flag);
                        $display("  actual   seq %0d char %0d payload %h sum %0d last %0b",
                                 m_seq_number, m_seq_char, m_payload_out, m_sum_out,
                                 m_last_packet);
                    end
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", quiet_cycles);
            $display("go_back_n_window_sender test failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_LOAD;
        s_chunk_bytes = '0;
        s_ack_value = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW_LIMIT;
        cfg_wdata = '0;
        loaded_count = '0;
        base_idx = '0;
        send_idx = '0;
        tick_count = '0;
        sending = 1'b0;
        win_reg = WINDOW_LIMIT_RST;
        timeout_reg = TIMEOUT_RST;
        walk_len = 0;
        for (int i = 0; i < STORE_DEPTH; i++) acked[i] = 1'b0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults_and_acks();
        test_timer_go_back();
        test_random_traffic();
        test_long_walk();
        settle_sender();

        $display("covered %0d loads, %0d starts, %0d acks, %0d ticks, %0d register writes",
                 item_tally[CMD_LOAD], item_tally[CMD_START], item_tally[CMD_ACK],
                 item_tally[CMD_TICK], reg_writes);
        $display("checked %0d packets, %0d mismatches", packets_seen, mismatches);
        if (mismatches == 0) begin
            $display("go_back_n_window_sender test passed");
        end else begin
            $display("go_back_n_window_sender test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/gbn_mac.sv
hdl/go_back_n_window_sender.sv
verif/go_back_n_window_sender_test.sv
